FILE: rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Operation codes, status codes and sequencer states shared by the queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  // Operation carried with each input item.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_PEEK   = 2'd2
  } mhpq_mode_t;

  // Status returned with each result item.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } mhpq_status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PEEK_LD = 3'd1,
    ST_DEL_LD  = 3'd2,
    ST_UP      = 3'd3,
    ST_UP_CMP  = 3'd4,
    ST_DN      = 3'd5,
    ST_DN_CMP  = 3'd6,
    ST_RESP    = 3'd7
  } mhpq_state_t;

  localparam int unsigned KEY_OUT_W   = 32;
  localparam int unsigned COUNT_OUT_W = 11;
  localparam int unsigned OUT_DATA_W  = 48;

endpackage

FILE: rtl/min_heap_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Binary min-heap of signed keys held in a RAM; insert, delete-min and peek.
//
//   Channel  Direction  tdata                            tuser
//   in_      slave      [31:0] key_in                    [1:0] mode
//   out_     master     [31:0] key_out, [42:32] count    [1:0] status
//
// Each item is worked on alone: an insert moves the key up from the new last
// slot, a delete sinks the last entry from the root, a peek reads the root,
// and the empty, full and no-op cases go straight to the response. Each level
// the key moves through costs one compare against the registered RAM reads.
// A new item is taken while a result still waits; a second result stalls.
// Reset clears the entry count and the control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_top #(
  parameter int unsigned CAPACITY  = 1024,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] key_in
  input  logic [1:0]  in_tuser,   // [1:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [mhpq_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] key_out, [42:32] count_out
  output logic [1:0]  out_tuser   // [1:0] status
);

  import mhpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  // Sequencer and heap state.
  mhpq_state_t state_r, state_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic signed [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [KEY_OUT_W-1:0] res_key_r, res_key_nxt;
  mhpq_status_t         res_stat_r, res_stat_nxt;

  // Output stage.
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_load;
  logic [KEY_OUT_W-1:0]   out_key_r;
  mhpq_status_t           out_stat_r;
  logic [COUNT_OUT_W-1:0] out_count_r;

  // RAM ports.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_ra_addr;
  logic [AW-1:0]        ram_rb_addr;
  logic [KEY_WIDTH-1:0] ram_ra_data;
  logic [KEY_WIDTH-1:0] ram_rb_data;
  logic signed [KEY_WIDTH-1:0] ra_key;
  logic signed [KEY_WIDTH-1:0] rb_key;

  // Index arithmetic.
  logic [AW-1:0] par_idx;
  logic [AW-1:0] grand_idx;
  logic [IW-1:0] lc_idx;
  logic [IW-1:0] rc_idx;
  logic [IW-1:0] cnt_ext;
  logic          rc_ok;
  logic          pick_right;
  logic [AW-1:0] child_idx;
  logic signed [KEY_WIDTH-1:0] child_key;
  logic [IW-1:0] child_lc;
  logic [IW-1:0] child_rc;
  logic signed [31:0] key_in_s;

  mhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ram_ra_addr),
    .ra_data (ram_ra_data),
    .rb_addr (ram_rb_addr),
    .rb_data (ram_rb_data)
  );

  assign ra_key   = signed'(ram_ra_data);
  assign rb_key   = signed'(ram_rb_data);
  assign key_in_s = signed'(in_tdata[31:0]);

  // Parent and children of the current hole, and the smaller child.
  assign par_idx    = (pos_r - AW'(1)) >> 1;
  assign grand_idx  = (par_idx - AW'(1)) >> 1;
  assign lc_idx     = {1'b0, pos_r, 1'b1};
  assign rc_idx     = lc_idx + IW'(1);
  assign cnt_ext    = IW'(count_r);
  assign rc_ok      = rc_idx < cnt_ext;
  assign pick_right = rc_ok && (rb_key < ra_key);
  assign child_idx  = pick_right ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
  assign child_key  = pick_right ? rb_key : ra_key;
  assign child_lc   = {1'b0, child_idx, 1'b1};
  assign child_rc   = child_lc + IW'(1);

  assign in_tready = (state_r == ST_IDLE);

  // Next state, heap walk and RAM access.
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    key_nxt      = key_r;
    count_nxt    = count_r;
    res_key_nxt  = res_key_r;
    res_stat_nxt = res_stat_r;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = key_r;
    ram_ra_addr  = '0;
    ram_rb_addr  = '0;
    out_load     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          res_key_nxt  = '0;
          res_stat_nxt = STAT_OK;
          state_nxt    = ST_RESP;
          case (mhpq_mode_t'(in_tuser))
            MODE_INSERT: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_stat_nxt = STAT_FULL;
              end else begin
                key_nxt   = KEY_WIDTH'(key_in_s);
                pos_nxt   = AW'(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = ST_UP;
              end
            end
            MODE_DELETE: begin
              if (count_r == '0) begin
                res_stat_nxt = STAT_EMPTY;
              end else begin
                // Fetch the root and the last entry together.
                ram_ra_addr = '0;
                ram_rb_addr = AW'(count_r - CW'(1));
                count_nxt   = count_r - CW'(1);
                state_nxt   = ST_DEL_LD;
              end
            end
            MODE_PEEK: begin
              if (count_r == '0) begin
                res_stat_nxt = STAT_EMPTY;
              end else begin
                ram_ra_addr = '0;
                state_nxt   = ST_PEEK_LD;
              end
            end
            default: begin
              res_stat_nxt = STAT_OK;
            end
          endcase
        end
      end

      ST_PEEK_LD: begin
        res_key_nxt = KEY_OUT_W'(ra_key);
        state_nxt   = ST_RESP;
      end

      ST_DEL_LD: begin
        // The last entry becomes the key that sinks from the root.
        res_key_nxt = KEY_OUT_W'(ra_key);
        key_nxt     = rb_key;
        pos_nxt     = '0;
        state_nxt   = ST_DN;
      end

      ST_UP: begin
        if (pos_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          ram_ra_addr = par_idx;
          state_nxt   = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        // A smaller key moves the parent down into the hole.
        if (key_r < ra_key) begin
          ram_we    = 1'b1;
          ram_wdata = ram_ra_data;
          pos_nxt   = par_idx;
          if (par_idx == '0) begin
            state_nxt = ST_UP;
          end else begin
            ram_ra_addr = grand_idx;
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_DN: begin
        if (lc_idx >= cnt_ext) begin
          ram_we    = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          ram_ra_addr = lc_idx[AW-1:0];
          ram_rb_addr = rc_idx[AW-1:0];
          state_nxt   = ST_DN_CMP;
        end
      end

      ST_DN_CMP: begin
        // The smaller child, left on a tie, moves up into the hole.
        if (child_key < key_r) begin
          ram_we    = 1'b1;
          ram_wdata = KEY_WIDTH'(child_key);
          pos_nxt   = child_idx;
          if (child_lc < cnt_ext) begin
            ram_ra_addr = child_lc[AW-1:0];
            ram_rb_addr = child_rc[AW-1:0];
          end else begin
            state_nxt = ST_DN;
          end
        end else begin
          ram_we    = 1'b1;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    res_key_r  <= res_key_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_key_r   <= res_key_r;
      out_stat_r  <= res_stat_r;
      out_count_r <= COUNT_OUT_W'(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - KEY_OUT_W - COUNT_OUT_W)'(0), out_count_r, out_key_r};
  assign out_tuser  = out_stat_r;

`ifndef SYNTHESIS
  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A dropped insert is reported only with a full heap.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_FULL) |-> out_tdata[42:32] == COUNT_OUT_W'(CAPACITY))
    else $error("full status with heap not full");

  // An empty status is reported only with no entries held.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY) |-> out_tdata[42:32] == '0)
    else $error("empty status with entries held");

  // The heap RAM is written only while an item is being worked on.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE) && (state_r != ST_RESP))
    else $error("heap write outside an operation");
`endif

endmodule

FILE: rtl/mhpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, each read registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and the two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule
